// File: design/gjmd_pkg.sv
// ----------------------------------------------------------------------------
// gjmd_pkg
// Shared widths, codes, types and helpers for the minimal joined diameter block.
// ----------------------------------------------------------------------------
`default_nettype none

package gjmd_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int PAIR_W    = 2 * NODE_W;
    localparam int NC_W      = 7;
    localparam int COORD_W   = 17;
    localparam int FRAC_BITS = 16;
    localparam int LEN_W     = 40;
    localparam int SQ_W      = 2 * COORD_W + 1;
    localparam int ROOT_W    = 20 + FRAC_BITS;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int CNT_W     = $clog2(ROOT_W);
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic OP_COORD = 1'b0;
    localparam logic OP_LINK  = 1'b1;

    localparam logic [ADDR_W-3:0] REG_NODE_COUNT = '0;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } dist_req_t;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/gjmd_ram.sv
// ----------------------------------------------------------------------------
// gjmd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gjmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/gjmd_dist.sv
// ----------------------------------------------------------------------------
// gjmd_dist
// Euclidean distance unit: one shared multiplier squares dx and dy, then a
// restoring square root produces one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gjmd_dist (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gjmd_pkg::dist_req_t   req,
    output logic                       done,
    output logic [gjmd_pkg::LEN_W-1:0] length
);

    import gjmd_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_SQX, D_SQY, D_ROOT} dstate_t;

    dstate_t            state_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [LEN_W-1:0]   length_reg;

    logic [COORD_W-1:0]   mul_in;
    logic [2*COORD_W-1:0] prod;
    logic [SQ_W-1:0]      sum_sq;
    logic [REM_W-1:0]     rem_sh, trial, rem_next;
    logic [ROOT_W-1:0]    root_next;

    // the single multiplier, shared between the two squares
    assign mul_in = (state_reg == D_SQX) ? dx_reg : dy_reg;
    assign prod   = mul_in * mul_in;
    assign sum_sq = sq_reg + SQ_W'(prod);

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        dx_reg    <= (req.ax >= req.bx) ? req.ax - req.bx : req.bx - req.ax;
                        dy_reg    <= (req.ay >= req.by) ? req.ay - req.by : req.by - req.ay;
                        state_reg <= D_SQX;
                    end
                end
                D_SQX:
                begin
                    sq_reg    <= SQ_W'(prod);
                    state_reg <= D_SQY;
                end
                D_SQY:
                begin
                    // radicand carries the squared distance scaled by 2^(2*frac)
                    rad_reg   <= RAD_W'(sum_sq) << (2 * FRAC_BITS);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= D_ROOT;
                end
                D_ROOT:
                begin
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    rad_reg  <= rad_reg << 2;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                    begin
                        length_reg <= LEN_W'(root_next);
                        done_reg   <= 1'b1;
                        state_reg  <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign length = length_reg;

endmodule

`default_nettype wire

// File: design/graph_join_min_diameter.sv
// ----------------------------------------------------------------------------
// graph_join_min_diameter
// Loads node coordinates and a directed adjacency matrix, then computes the
// minimal diameter reachable by joining two unreached nodes (all pairs
// shortest path by Floyd-Warshall over fixed-point Euclidean edge lengths).
// ----------------------------------------------------------------------------
// Load transactions are accepted while the block is idle. The transaction
// marked last starts the computation and the block stalls its input until
// the computation has finished. The result register holds one finished
// result, so loads go on while it waits, and a later computation only ends
// once that result has been taken. With n nodes the computation first steps
// through every pair for the edge weights (a linked pair goes through the
// bit-serial square root, one bit per cycle, in the distance unit), then
// through each (k,i) row and its (k,i,j) triples for the relaxation, paced
// by the single read port of the path memory, then through every pair for
// the eccentricities, and through every pair again for the join search,
// which runs the distance unit for each unreached pair.
`default_nettype none

module graph_join_min_diameter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [gjmd_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [gjmd_pkg::DATA_W-1:0]       pwdata,
    output logic      [gjmd_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [gjmd_pkg::NODE_W-1:0]       node_a,
    input  wire logic [gjmd_pkg::NODE_W-1:0]       node_b,
    input  wire logic [gjmd_pkg::COORD_W-1:0]      coord_x,
    input  wire logic [gjmd_pkg::COORD_W-1:0]      coord_y,
    input  wire logic                              linked,
    input  wire logic                              last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [gjmd_pkg::LEN_W-1:0]        diameter,
    output logic                                   no_join_pair
);

    import gjmd_pkg::*;

    typedef enum logic [4:0] {
        IDLE, W_A, W_B, W_C, W_D,
        F_IK, F_IKC, F_J, F_KJ, F_UP,
        E_RD, E_AC,
        J_RD, J_B, J_C, J_D,
        DONE
    } state_t;

    state_t              state_reg;
    logic [NC_W-1:0]     node_count_reg;
    logic [NODE_W-1:0]   i_reg, j_reg, k_reg;
    logic [2*COORD_W-1:0] ci_reg;
    logic                rij_reg, rkj_reg;
    logic [LEN_W-1:0]    pik_reg, pkj_reg;
    logic [LEN_W-1:0]    row_max_reg, ecc_max_reg, ei_reg, esum_reg, best_reg;
    logic                found_reg;
    logic                out_valid_reg, flag_reg;
    logic [LEN_W-1:0]    diameter_reg;

    logic [NC_W-1:0]     n, n_m1;
    logic                i_last, j_last, k_last;
    logic                in_acc, cfg_wr;

    logic                 coord_we;
    logic [NODE_W-1:0]    coord_raddr;
    logic [2*COORD_W-1:0] coord_q;
    logic                 reach_we, reach_wdata, reach_q;
    logic [PAIR_W-1:0]    reach_waddr, reach_raddr;
    logic                 path_we;
    logic [LEN_W-1:0]     path_wdata, path_q;
    logic [PAIR_W-1:0]    path_raddr;
    logic                 ecc_we;
    logic [NODE_W-1:0]    ecc_raddr;
    logic [LEN_W-1:0]     ecc_q;

    logic [LEN_W-1:0]    s_fw, s_jn, row_new;
    dist_req_t           dreq;
    logic                dist_done;
    logic [LEN_W-1:0]    dist_len;
    logic                fw_row_end;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[ADDR_W-1:2] == REG_NODE_COUNT)
                    ? DATA_W'(node_count_reg) : '0;

    // effective node count
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n = NC_W'(1);
        end
        else if (node_count_reg > NC_W'(MAX_NODES))
        begin
            n = NC_W'(MAX_NODES);
        end
        else
        begin
            n = node_count_reg;
        end
    end

    assign n_m1   = n - 1'b1;
    assign i_last = (NC_W'(i_reg) == n_m1);
    assign j_last = (NC_W'(j_reg) == n_m1);
    assign k_last = (NC_W'(k_reg) == n_m1);

    assign in_stall = (state_reg != IDLE);
    assign in_acc   = in_valid && !in_stall;

    // memory port steering
    assign coord_we    = in_acc && (operation == OP_COORD);
    assign coord_raddr = (state_reg == W_B || state_reg == J_B) ? j_reg : i_reg;

    assign reach_we    = (in_acc && (operation == OP_LINK)) || (state_reg == F_UP && rkj_reg);
    assign reach_waddr = (state_reg == IDLE) ? {node_a, node_b} : {i_reg, j_reg};
    assign reach_wdata = (state_reg == IDLE) ? linked : 1'b1;

    always_comb
    begin
        case (state_reg)
            F_IK:    reach_raddr = {i_reg, k_reg};
            F_J:     reach_raddr = {k_reg, j_reg};
            default: reach_raddr = {i_reg, j_reg};
        endcase
    end
    assign path_raddr = reach_raddr;

    assign s_fw = sat_add(pik_reg, pkj_reg);
    assign s_jn = sat_add(esum_reg, dist_len);

    always_comb
    begin
        path_we    = 1'b0;
        path_wdata = LEN_MAX;
        case (state_reg)
            W_C:
            begin
                path_we = !rij_reg;
            end
            W_D:
            begin
                path_we    = dist_done;
                path_wdata = dist_len;
            end
            F_UP:
            begin
                path_we    = rkj_reg;
                path_wdata = (s_fw < path_q) ? s_fw : path_q;
            end
            default:
            begin
                path_we = 1'b0;
            end
        endcase
    end

    assign row_new   = (reach_q && path_q > row_max_reg) ? path_q : row_max_reg;
    assign ecc_we    = (state_reg == E_AC) && j_last;
    assign ecc_raddr = (state_reg == J_B) ? j_reg : i_reg;

    assign dreq.start = (state_reg == W_C && rij_reg) || (state_reg == J_C);
    assign dreq.ax    = ci_reg[2*COORD_W-1:COORD_W];
    assign dreq.ay    = ci_reg[COORD_W-1:0];
    assign dreq.bx    = coord_q[2*COORD_W-1:COORD_W];
    assign dreq.by    = coord_q[COORD_W-1:0];

    // move on to the next row of the relaxation
    always_comb
    begin
        case (state_reg)
            F_IK:    fw_row_end = (i_reg == k_reg);
            F_IKC:   fw_row_end = !reach_q;
            F_J:     fw_row_end = ((j_reg == i_reg) || (j_reg == k_reg)) && j_last;
            F_UP:    fw_row_end = j_last;
            default: fw_row_end = 1'b0;
        endcase
    end

    gjmd_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_NODES)) u_coord_ram (
        .clk   (clk),
        .we    (coord_we),
        .waddr (node_a),
        .wdata ({coord_x, coord_y}),
        .raddr (coord_raddr),
        .rdata (coord_q)
    );

    gjmd_ram #(.WIDTH(1), .DEPTH(MAX_NODES*MAX_NODES)) u_reach_ram (
        .clk   (clk),
        .we    (reach_we),
        .waddr (reach_waddr),
        .wdata (reach_wdata),
        .raddr (reach_raddr),
        .rdata (reach_q)
    );

    gjmd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES*MAX_NODES)) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr ({i_reg, j_reg}),
        .wdata (path_wdata),
        .raddr (path_raddr),
        .rdata (path_q)
    );

    gjmd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_ecc_ram (
        .clk   (clk),
        .we    (ecc_we),
        .waddr (i_reg),
        .wdata (row_new),
        .raddr (ecc_raddr),
        .rdata (ecc_q)
    );

    gjmd_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dreq),
        .done   (dist_done),
        .length (dist_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            node_count_reg <= NC_W'(MAX_NODES);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[ADDR_W-1:2] == REG_NODE_COUNT)
            begin
                node_count_reg <= pwdata[NC_W-1:0];
            end
            // result register frees up when its transaction is taken
            if (state_reg == DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (in_acc && last)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= W_A;
                    end
                end

                // edge weights
                W_A:
                begin
                    state_reg <= W_B;
                end
                W_B:
                begin
                    ci_reg    <= coord_q;
                    rij_reg   <= reach_q;
                    state_reg <= W_C;
                end
                W_C, W_D:
                begin
                    if (state_reg == W_C && rij_reg)
                    begin
                        state_reg <= W_D;
                    end
                    else if (state_reg == W_C || dist_done)
                    begin
                        state_reg <= W_A;
                        if (j_last)
                        begin
                            j_reg <= '0;
                            if (i_last)
                            begin
                                i_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= F_IK;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end

                // relaxation
                F_IK:
                begin
                    state_reg <= F_IKC;
                end
                F_IKC:
                begin
                    pik_reg   <= path_q;
                    j_reg     <= '0;
                    state_reg <= F_J;
                end
                F_J:
                begin
                    if ((j_reg == i_reg) || (j_reg == k_reg))
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= F_KJ;
                    end
                end
                F_KJ:
                begin
                    pkj_reg   <= path_q;
                    rkj_reg   <= reach_q;
                    state_reg <= F_UP;
                end
                F_UP:
                begin
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= F_J;
                end

                // eccentricities
                E_RD:
                begin
                    state_reg <= E_AC;
                end
                E_AC:
                begin
                    state_reg <= E_RD;
                    if (j_last)
                    begin
                        j_reg       <= '0;
                        row_max_reg <= '0;
                        if (row_new > ecc_max_reg)
                        begin
                            ecc_max_reg <= row_new;
                        end
                        if (i_last)
                        begin
                            i_reg     <= '0;
                            found_reg <= 1'b0;
                            state_reg <= J_RD;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        row_max_reg <= row_new;
                        j_reg       <= j_reg + 1'b1;
                    end
                end

                // join search over unreached pairs
                J_RD, J_B, J_C, J_D:
                begin
                    if (state_reg == J_RD && i_reg != j_reg)
                    begin
                        state_reg <= J_B;
                    end
                    else if (state_reg == J_B && !reach_q)
                    begin
                        ci_reg    <= coord_q;
                        ei_reg    <= ecc_q;
                        state_reg <= J_C;
                    end
                    else if (state_reg == J_C)
                    begin
                        esum_reg  <= sat_add(ei_reg, ecc_q);
                        state_reg <= J_D;
                    end
                    else if (state_reg != J_D || dist_done)
                    begin
                        if (state_reg == J_D && (!found_reg || s_jn < best_reg))
                        begin
                            best_reg  <= s_jn;
                            found_reg <= 1'b1;
                        end
                        state_reg <= J_RD;
                        if (j_last)
                        begin
                            j_reg <= '0;
                            if (i_last)
                            begin
                                state_reg <= DONE;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end

                // wait here while the previous result is still held
                DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if (found_reg && best_reg > ecc_max_reg)
                        begin
                            diameter_reg <= best_reg;
                        end
                        else
                        begin
                            diameter_reg <= ecc_max_reg;
                        end
                        flag_reg  <= !found_reg;
                        state_reg <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase

            // end of a relaxation row overrides the per-state step
            if (fw_row_end)
            begin
                state_reg <= F_IK;
                if (i_last)
                begin
                    i_reg <= '0;
                    if (k_last)
                    begin
                        j_reg       <= '0;
                        row_max_reg <= '0;
                        ecc_max_reg <= '0;
                        state_reg   <= E_RD;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign diameter     = diameter_reg;
    assign no_join_pair = flag_reg;

endmodule

`default_nettype wire
